@@ hw/rtl/pbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// pbpm_pkg
// Shared types and constants of the page buffer pool manager.
// ----------------------------------------------------------------------------
package pbpm_pkg;

    localparam int FRAMES_DEF       = 16;
    localparam int PAGE_ID_BITS_DEF = 32;
    localparam int PIN_BITS_DEF     = 8;

    localparam int MODE_W   = 3;
    localparam int PAGE_W   = 32;
    localparam int STATUS_W = 3;
    localparam int FRAME_W  = 4;
    localparam int PINS_W   = 8;
    localparam int AVAIL_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_FETCH     = 3'd0,
        MODE_NEW       = 3'd1,
        MODE_UNPIN     = 3'd2,
        MODE_DIRTY     = 3'd3,
        MODE_FLUSH     = 3'd4,
        MODE_FLUSH_ALL = 3'd5,
        MODE_DELETE    = 3'd6,
        MODE_RSVD      = 3'd7
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_INVALID      = 3'd1,
        ST_ALL_PINNED   = 3'd2,
        ST_NOT_RESIDENT = 3'd3,
        ST_NOT_PINNED   = 3'd4,
        ST_PINNED       = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        LRU_NOP,
        LRU_PUSH,
        LRU_REMOVE,
        LRU_EVICT
    } lru_op_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PAGE_W-1:0] page;
        logic              dirty_flag;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic                hit;
        logic                load_needed;
        logic                writeback;
        logic [PAGE_W-1:0]   out_page;
        logic [PINS_W-1:0]   pins;
        logic [AVAIL_W-1:0]  available;
        logic                last;
    } res_t;

endpackage

@@ hw/rtl/pbpm_lru_list.sv @@
// ----------------------------------------------------------------------------
// pbpm_lru_list
// Ordered list of unpinned frames, oldest first; one entry walked per cycle.
// ----------------------------------------------------------------------------
module pbpm_lru_list
    import pbpm_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF,
    localparam int FB = $clog2(FRAMES),
    localparam int CW = $clog2(FRAMES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lru_op_t       op,
    input  logic [FB-1:0] op_frame,
    output logic          done,
    output logic [FB-1:0] victim,
    output logic [CW-1:0] count
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_SEARCH,
        L_SHIFT,
        L_HEAD
    } lstate_t;

    lstate_t       state_reg;
    logic [FB-1:0] order_mem [FRAMES];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] p_reg;
    logic [CW-1:0] p_inc;
    logic [FB-1:0] tgt_reg;
    logic [FB-1:0] victim_reg;
    logic          done_reg;
    logic [FB-1:0] rd_addr;
    logic [FB-1:0] rd_data;

    assign p_inc   = p_reg + 1'b1;
    assign rd_addr = (state_reg == L_SHIFT) ? p_inc[FB-1:0] : p_reg[FB-1:0];
    assign rd_data = order_mem[rd_addr];

    always_ff @(posedge clk)
    begin
        if (state_reg == L_IDLE && op == LRU_PUSH && cnt_reg < CW'(FRAMES))
        begin
            order_mem[cnt_reg[FB-1:0]] <= op_frame;
        end
        else if (state_reg == L_SHIFT && p_inc < cnt_reg)
        begin
            order_mem[p_reg[FB-1:0]] <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            p_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                begin
                    unique case (op)
                        LRU_PUSH:
                        begin
                            if (cnt_reg < CW'(FRAMES))
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            done_reg <= 1'b1;
                        end
                        LRU_REMOVE:
                        begin
                            tgt_reg   <= op_frame;
                            p_reg     <= '0;
                            state_reg <= L_SEARCH;
                        end
                        LRU_EVICT:
                        begin
                            p_reg     <= '0;
                            state_reg <= L_HEAD;
                        end
                        LRU_NOP:
                        begin
                        end
                    endcase
                end
                L_SEARCH:
                begin
                    priority if (p_reg >= cnt_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                    else if (rd_data == tgt_reg)
                    begin
                        state_reg <= L_SHIFT;
                    end
                    else
                    begin
                        p_reg <= p_inc;
                    end
                end
                L_HEAD:
                begin
                    victim_reg <= rd_data;
                    state_reg  <= L_SHIFT;
                end
                L_SHIFT:
                begin
                    if (p_inc < cnt_reg)
                    begin
                        p_reg <= p_inc;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - 1'b1;
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign victim = victim_reg;
    assign count  = cnt_reg;

endmodule

@@ hw/rtl/page_buffer_pool_manager.sv @@
// ----------------------------------------------------------------------------
// page_buffer_pool_manager
// Frame table with pin counts, free-frame stack and LRU replacement.
//
//   channel   handshake       payload   direction
//   request   start / busy    req       in
//   result    valid strobe    result    out
//
// lookup compares one frame per cycle, then dispatches and gives the final
// result; a miss installs a frame taken from the free stack or from an LRU
// eviction, written back first if dirty; fetch, unpin and delete may wait
// for a walk of the LRU list; flush all walks every frame. reset clears all
// flags, pin counts and counters at once and loads the free stack; there is no clearing pass. results are
// strobed for one cycle each and the receiver cannot stall them.
// ----------------------------------------------------------------------------
module page_buffer_pool_manager
    import pbpm_pkg::*;
#(
    parameter int FRAMES       = FRAMES_DEF,
    parameter int PAGE_ID_BITS = PAGE_ID_BITS_DEF,
    parameter int PIN_BITS     = PIN_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic valid,
    output res_t result
);

    localparam int FB = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int PB = PAGE_ID_BITS;
    localparam int PW = PIN_BITS;
    localparam logic [FB-1:0] LAST_FRAME = FB'(FRAMES - 1);
    localparam logic [PW-1:0] PIN_MAX = {PW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DISPATCH,
        S_WAIT_LRU,
        S_EVICT_WB,
        S_INSTALL,
        S_FLUSH,
        S_FLUSH_END,
        S_FINAL
    } state_t;

    state_t            state_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [PB-1:0]     pg_reg;
    logic              dflag_reg;
    logic [FB-1:0]     idx_reg;
    logic [FB-1:0]     found_idx_reg;
    logic              found_reg;
    logic              after_evict_reg;
    res_t              fin_reg;
    res_t              result_reg;
    logic              valid_reg;
    lru_op_t           lru_op_reg;
    logic [FB-1:0]     lru_frame_reg;

    logic [PB-1:0]     page_mem [FRAMES];
    logic              frame_valid_reg [FRAMES];
    logic              frame_dirty_reg [FRAMES];
    logic [PW-1:0]     frame_pins_reg [FRAMES];
    logic [FB-1:0]     free_reg [FRAMES];
    logic [CW-1:0]     fc_reg;

    logic              lru_done;
    logic [FB-1:0]     lru_victim;
    logic [CW-1:0]     lru_cnt;

    logic [PB-1:0]     cur_page;
    logic              cur_valid;
    logic              cur_dirty;
    logic [PW-1:0]     cur_pins;
    logic [CW-1:0]     fc_m1;
    logic [FB-1:0]     free_top;
    logic [CW:0]       avail_sum;
    logic [AVAIL_W-1:0] avail;
    logic [FRAME_W-1:0] cur_frame_out;
    logic [PINS_W-1:0] cur_pins_out;
    logic              pg_bad;
    res_t              fin_base;

    pbpm_lru_list #(
        .FRAMES (FRAMES)
    ) u_lru (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (lru_op_reg),
        .op_frame (lru_frame_reg),
        .done     (lru_done),
        .victim   (lru_victim),
        .count    (lru_cnt)
    );

    assign cur_page      = page_mem[idx_reg];
    assign cur_valid     = frame_valid_reg[idx_reg];
    assign cur_dirty     = frame_dirty_reg[idx_reg];
    assign cur_pins      = frame_pins_reg[idx_reg];
    assign fc_m1         = fc_reg - 1'b1;
    assign free_top      = free_reg[fc_m1[FB-1:0]];
    assign avail_sum     = (CW+1)'(fc_reg) + (CW+1)'(lru_cnt);
    assign avail         = AVAIL_W'(avail_sum);
    assign cur_frame_out = FRAME_W'(idx_reg);
    assign cur_pins_out  = PINS_W'(cur_pins);
    assign pg_bad        = (pg_reg == {PB{1'b1}});

    always_comb
    begin
        fin_base          = '0;
        fin_base.status   = ST_OK;
        fin_base.out_page = PAGE_W'(pg_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_INSTALL)
        begin
            page_mem[idx_reg] <= pg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= 1'b0;
            lru_op_reg <= LRU_NOP;
            fc_reg     <= CW'(FRAMES);
            found_reg  <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                frame_valid_reg[i] <= 1'b0;
                frame_dirty_reg[i] <= 1'b0;
                frame_pins_reg[i]  <= '0;
                free_reg[i]        <= FB'(i);
            end
        end
        else
        begin
            valid_reg  <= 1'b0;
            lru_op_reg <= LRU_NOP;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg  <= req.mode;
                        pg_reg    <= PB'(req.page);
                        dflag_reg <= req.dirty_flag;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    priority if (cur_valid && cur_page == pg_reg)
                    begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= idx_reg;
                        state_reg     <= S_DISPATCH;
                    end
                    else if (idx_reg == LAST_FRAME)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DISPATCH:
                begin
                    fin_reg   <= fin_base;
                    state_reg <= S_FINAL;
                    priority if (mode_reg != MODE_FLUSH_ALL && mode_reg <= MODE_DELETE
                                 && pg_bad)
                    begin
                        fin_reg.status <= ST_INVALID;
                    end
                    else if ((mode_reg == MODE_FETCH || mode_reg == MODE_NEW) && !found_reg)
                    begin
                        priority if (fc_reg != '0)
                        begin
                            idx_reg   <= free_top;
                            fc_reg    <= fc_m1;
                            state_reg <= S_INSTALL;
                        end
                        else if (lru_cnt == '0)
                        begin
                            fin_reg.status <= ST_ALL_PINNED;
                        end
                        else
                        begin
                            lru_op_reg      <= LRU_EVICT;
                            after_evict_reg <= 1'b1;
                            state_reg       <= S_WAIT_LRU;
                        end
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_FETCH:
                            begin
                                fin_reg.frame <= cur_frame_out;
                                fin_reg.hit   <= 1'b1;
                                if (cur_pins == PIN_MAX)
                                begin
                                    fin_reg.status <= ST_PINNED;
                                    fin_reg.pins   <= cur_pins_out;
                                end
                                else
                                begin
                                    frame_pins_reg[idx_reg] <= cur_pins + 1'b1;
                                    fin_reg.pins    <= PINS_W'(PW'(cur_pins + 1'b1));
                                    lru_op_reg      <= LRU_REMOVE;
                                    lru_frame_reg   <= idx_reg;
                                    after_evict_reg <= 1'b0;
                                    state_reg       <= S_WAIT_LRU;
                                end
                            end
                            MODE_NEW:
                            begin
                                fin_reg.status <= ST_INVALID;
                                fin_reg.frame  <= cur_frame_out;
                                fin_reg.pins   <= cur_pins_out;
                            end
                            MODE_UNPIN:
                            begin
                                priority if (!found_reg)
                                begin
                                    fin_reg.status <= ST_NOT_RESIDENT;
                                end
                                else if (cur_pins == '0)
                                begin
                                    fin_reg.status <= ST_NOT_PINNED;
                                    fin_reg.frame  <= cur_frame_out;
                                end
                                else
                                begin
                                    frame_pins_reg[idx_reg] <= cur_pins - 1'b1;
                                    if (dflag_reg)
                                    begin
                                        frame_dirty_reg[idx_reg] <= 1'b1;
                                    end
                                    fin_reg.frame <= cur_frame_out;
                                    fin_reg.pins  <= PINS_W'(PW'(cur_pins - 1'b1));
                                    if (cur_pins == PW'(1))
                                    begin
                                        lru_op_reg      <= LRU_PUSH;
                                        lru_frame_reg   <= idx_reg;
                                        after_evict_reg <= 1'b0;
                                        state_reg       <= S_WAIT_LRU;
                                    end
                                end
                            end
                            MODE_DIRTY:
                            begin
                                if (!found_reg)
                                begin
                                    fin_reg.status <= ST_NOT_RESIDENT;
                                end
                                else
                                begin
                                    frame_dirty_reg[idx_reg] <= 1'b1;
                                    fin_reg.frame <= cur_frame_out;
                                    fin_reg.pins  <= cur_pins_out;
                                end
                            end
                            MODE_FLUSH:
                            begin
                                if (found_reg)
                                begin
                                    frame_dirty_reg[idx_reg] <= 1'b0;
                                    fin_reg.frame     <= cur_frame_out;
                                    fin_reg.writeback <= cur_dirty;
                                    fin_reg.pins      <= cur_pins_out;
                                end
                            end
                            MODE_FLUSH_ALL:
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_FLUSH;
                            end
                            MODE_DELETE:
                            begin
                                if (found_reg)
                                begin
                                    fin_reg.frame <= cur_frame_out;
                                    if (cur_pins != '0)
                                    begin
                                        fin_reg.status <= ST_PINNED;
                                        fin_reg.pins   <= cur_pins_out;
                                    end
                                    else
                                    begin
                                        frame_valid_reg[idx_reg] <= 1'b0;
                                        frame_dirty_reg[idx_reg] <= 1'b0;
                                        if (fc_reg < CW'(FRAMES))
                                        begin
                                            free_reg[fc_reg[FB-1:0]] <= idx_reg;
                                            fc_reg <= fc_reg + 1'b1;
                                        end
                                        lru_op_reg      <= LRU_REMOVE;
                                        lru_frame_reg   <= idx_reg;
                                        after_evict_reg <= 1'b0;
                                        state_reg       <= S_WAIT_LRU;
                                    end
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_WAIT_LRU:
                begin
                    if (lru_done)
                    begin
                        if (after_evict_reg)
                        begin
                            idx_reg   <= lru_victim;
                            state_reg <= S_EVICT_WB;
                        end
                        else
                        begin
                            state_reg <= S_FINAL;
                        end
                    end
                end
                S_EVICT_WB:
                begin
                    if (cur_valid && cur_dirty)
                    begin
                        valid_reg             <= 1'b1;
                        result_reg            <= '0;
                        result_reg.status     <= ST_OK;
                        result_reg.frame      <= cur_frame_out;
                        result_reg.writeback  <= 1'b1;
                        result_reg.out_page   <= PAGE_W'(cur_page);
                        result_reg.available  <= avail;
                    end
                    frame_valid_reg[idx_reg] <= 1'b0;
                    frame_dirty_reg[idx_reg] <= 1'b0;
                    frame_pins_reg[idx_reg]  <= '0;
                    state_reg <= S_INSTALL;
                end
                S_INSTALL:
                begin
                    frame_valid_reg[idx_reg] <= 1'b1;
                    frame_dirty_reg[idx_reg] <= (mode_reg == MODE_NEW);
                    frame_pins_reg[idx_reg]  <= PW'(1);
                    fin_reg             <= fin_base;
                    fin_reg.frame       <= cur_frame_out;
                    fin_reg.load_needed <= (mode_reg == MODE_FETCH);
                    fin_reg.pins        <= PINS_W'(1);
                    state_reg <= S_FINAL;
                end
                S_FLUSH:
                begin
                    if (cur_valid && cur_dirty)
                    begin
                        frame_dirty_reg[idx_reg] <= 1'b0;
                        valid_reg             <= 1'b1;
                        result_reg            <= '0;
                        result_reg.status     <= ST_OK;
                        result_reg.frame      <= cur_frame_out;
                        result_reg.writeback  <= 1'b1;
                        result_reg.out_page   <= PAGE_W'(cur_page);
                        result_reg.pins       <= cur_pins_out;
                        result_reg.available  <= avail;
                    end
                    if (idx_reg == LAST_FRAME)
                    begin
                        idx_reg   <= found_idx_reg;
                        state_reg <= S_FLUSH_END;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FLUSH_END:
                begin
                    fin_reg <= fin_base;
                    if (found_reg)
                    begin
                        fin_reg.pins <= cur_pins_out;
                    end
                    state_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    valid_reg            <= 1'b1;
                    result_reg           <= fin_reg;
                    result_reg.available <= avail;
                    result_reg.last      <= 1'b1;
                    state_reg            <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign valid  = valid_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid && result.last |-> !busy)
        else $error("final item result while still busy");

    a_nonlast_wb: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !result.last |-> result.writeback)
        else $error("non-final result is not a write-back");

    a_avail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> avail_sum <= (CW+1)'(FRAMES))
        else $error("free plus evictable frames exceed pool size");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start the sequencer");

    a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        lru_op_reg == LRU_EVICT |-> lru_cnt != '0)
        else $error("eviction requested from an empty list");
`endif

endmodule
